### rtl/assert_macros.svh
// Assertion helpers shared by the RTL; each samples on clk and is quiet in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every edge.
`define CHK_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define CHK_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/q2s_pkg.sv
package q2s_pkg;

    localparam int VALUE_W   = 32;
    localparam int S_TDATA_W = 40;
    localparam int STATUS_W  = 3;

    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_XFER  = 2'd1;
    localparam logic [1:0] OP_LISTQ = 2'd2;
    localparam logic [1:0] OP_LISTS = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_QFULL  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_QEMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_SFULL  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ITEM   = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_LEMPTY = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_XFER,
        ST_LIST
    } state_t;

endpackage

### rtl/queue_to_stack_transfer.sv
// Ring-buffer queue and stack of signed 32-bit values, each DEPTH entries deep, held in two
// synchronous memories with registered read ports. One command is handled at a time.
// Enqueue, a transfer from an empty queue and listing an empty structure are answered
// without leaving the idle state. A transfer does the queue memory read, then the stack
// write if the stack has room. A listing takes the command, then issues one memory read
// per entry and, after the first read, streams one beat per cycle while the output is
// taken. Results sit in an output register; the next command is taken once that
// register is free or being emptied.
`include "assert_macros.svh"

module queue_to_stack_transfer #(
    parameter int DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [q2s_pkg::S_TDATA_W-1:0]       s_tdata,   // opcode[1:0], value[33:2], zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [q2s_pkg::VALUE_W-1:0]         m_tdata,   // value_res[31:0]
    output logic [q2s_pkg::STATUS_W-1:0]        m_tuser,   // status[2:0]
    output logic                                m_tlast
);
    import q2s_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_W  = (CW+1)'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [VALUE_W-1:0] queue_mem [DEPTH];
    logic [VALUE_W-1:0] stack_mem [DEPTH];

    state_t          state_reg, state_next;
    logic [AW-1:0]   qhead_reg, qhead_next;
    logic [CW-1:0]   qcount_reg, qcount_next;
    logic [CW-1:0]   scount_reg, scount_next;
    logic [AW-1:0]   lptr_reg, lptr_next;
    logic [CW-1:0]   lleft_reg, lleft_next;
    logic            lstack_reg, lstack_next;
    logic            pend_reg, pend_next;
    logic            plast_reg, plast_next;
    logic            ovalid_reg, ovalid_next;
    logic [STATUS_W-1:0] ostat_reg, ostat_next;
    logic [VALUE_W-1:0]  oval_reg, oval_next;
    logic            olast_reg, olast_next;

    logic [VALUE_W-1:0] qrd_reg, srd_reg;
    logic               q_we, s_we, q_re, s_re;
    logic [AW-1:0]      q_waddr, s_waddr, q_raddr, s_raddr;
    logic [VALUE_W-1:0] q_wdata, s_wdata;

    logic [1:0]         in_op;
    logic [VALUE_W-1:0] in_val;
    logic               out_free, accept, consume, issue;
    logic [CW:0]        tail_sum;
    logic [AW-1:0]      qtail;
    logic [VALUE_W-1:0] rd_data;

    logic               counts_ok, xfer_go, in_list, in_xfer;
    logic [CW-1:0]      qcnt_dec;

    assign in_op    = s_tdata[1:0];
    assign in_val   = s_tdata[VALUE_W+1:2];
    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = oval_reg;
    assign m_tuser  = ostat_reg;
    assign m_tlast  = olast_reg;

    // Tail slot of the ring: head plus count, wrapped once.
    assign tail_sum = {1'b0, CW'(qhead_reg)} + {1'b0, qcount_reg};
    assign qtail    = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);

    assign rd_data  = lstack_reg ? srd_reg : qrd_reg;
    assign consume  = (state_reg == ST_LIST) && pend_reg && out_free;
    assign issue    = (state_reg == ST_LIST) && (lleft_reg != '0) && (!pend_reg || consume);

    always_comb
    begin
        state_next  = state_reg;
        qhead_next  = qhead_reg;
        qcount_next = qcount_reg;
        scount_next = scount_reg;
        lptr_next   = lptr_reg;
        lleft_next  = lleft_reg;
        lstack_next = lstack_reg;
        pend_next   = pend_reg;
        plast_next  = plast_reg;
        ovalid_next = ovalid_reg && !m_tready;
        ostat_next  = ostat_reg;
        oval_next   = oval_reg;
        olast_next  = olast_reg;
        q_we    = 1'b0;
        q_waddr = qtail;
        q_wdata = in_val;
        q_re    = 1'b0;
        q_raddr = qhead_reg;
        s_we    = 1'b0;
        s_waddr = AW'(scount_reg);
        s_wdata = qrd_reg;
        s_re    = 1'b0;
        s_raddr = lptr_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = STAT_OK;
                    oval_next   = '0;
                    olast_next  = 1'b1;
                    unique case (in_op) inside
                        OP_ENQ:
                        begin
                            if (qcount_reg == DEPTH_C)
                                ostat_next = STAT_QFULL;
                            else
                            begin
                                q_we        = 1'b1;
                                qcount_next = qcount_reg + 1'b1;
                                oval_next   = in_val;
                            end
                        end
                        OP_XFER:
                        begin
                            if (qcount_reg == '0)
                                ostat_next = STAT_QEMPTY;
                            else
                            begin
                                // Hold the result back until the head entry is read.
                                ovalid_next = ovalid_reg && !m_tready;
                                ostat_next  = ostat_reg;
                                oval_next   = oval_reg;
                                olast_next  = olast_reg;
                                q_re        = 1'b1;
                                qhead_next  = (qhead_reg == LAST_IDX) ? '0 : qhead_reg + 1'b1;
                                qcount_next = qcount_reg - 1'b1;
                                state_next  = ST_XFER;
                            end
                        end
                        OP_LISTQ, OP_LISTS:
                        begin
                            if ((in_op == OP_LISTQ) ? (qcount_reg == '0) : (scount_reg == '0))
                                ostat_next = STAT_LEMPTY;
                            else
                            begin
                                ovalid_next = ovalid_reg && !m_tready;
                                ostat_next  = ostat_reg;
                                oval_next   = oval_reg;
                                olast_next  = olast_reg;
                                lstack_next = (in_op == OP_LISTS);
                                lptr_next   = (in_op == OP_LISTS) ?
                                              AW'(scount_reg - 1'b1) : qhead_reg;
                                lleft_next  = (in_op == OP_LISTS) ? scount_reg : qcount_reg;
                                pend_next   = 1'b0;
                                state_next  = ST_LIST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_XFER:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    olast_next  = 1'b1;
                    if (scount_reg == DEPTH_C)
                    begin
                        // Drop the moved value.
                        ostat_next = STAT_SFULL;
                        oval_next  = '0;
                    end
                    else
                    begin
                        s_we        = 1'b1;
                        scount_next = scount_reg + 1'b1;
                        ostat_next  = STAT_OK;
                        oval_next   = qrd_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_LIST:
            begin
                if (consume)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = STAT_ITEM;
                    oval_next   = rd_data;
                    olast_next  = plast_reg;
                    pend_next   = 1'b0;
                    if (plast_reg)
                        state_next = ST_IDLE;
                end
                if (issue)
                begin
                    q_re       = !lstack_reg;
                    s_re       = lstack_reg;
                    q_raddr    = lptr_reg;
                    pend_next  = 1'b1;
                    plast_next = (lleft_reg == CW'(1));
                    lleft_next = lleft_reg - 1'b1;
                    if (lstack_reg)
                        lptr_next = lptr_reg - 1'b1;
                    else
                        lptr_next = (lptr_reg == LAST_IDX) ? '0 : lptr_reg + 1'b1;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            qhead_reg  <= '0;
            qcount_reg <= '0;
            scount_reg <= '0;
            lleft_reg  <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            qhead_reg  <= qhead_next;
            qcount_reg <= qcount_next;
            scount_reg <= scount_next;
            lleft_reg  <= lleft_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lptr_reg   <= lptr_next;
        lstack_reg <= lstack_next;
        plast_reg  <= plast_next;
        ostat_reg  <= ostat_next;
        oval_reg   <= oval_next;
        olast_reg  <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            queue_mem[q_waddr] <= q_wdata;
        if (q_re)
            qrd_reg <= queue_mem[q_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
            stack_mem[s_waddr] <= s_wdata;
        if (s_re)
            srd_reg <= stack_mem[s_raddr];
    end

    assign counts_ok = (qcount_reg <= DEPTH_C) && (scount_reg <= DEPTH_C);
    assign xfer_go   = accept && (in_op == OP_XFER) && (qcount_reg != '0);
    assign in_list   = (state_reg == ST_LIST);
    assign in_xfer   = (state_reg == ST_XFER);
    assign qcnt_dec  = qcount_reg - 1'b1;

    `CHK_ALWAYS(a_counts_bounded, counts_ok, "count over depth")
    `CHK_IMPLIES(a_pend_in_list, pend_reg, in_list, "read pending outside listing")
    `CHK_IMPLIES(a_list_live, in_list, (lleft_reg != '0) || pend_reg, "listing stalled")
    `CHK_NEXT(a_xfer_pop, xfer_go, in_xfer && (qcount_reg == $past(qcnt_dec)), "pop missed")

endmodule

### verif/tb.sv
module tb;
    import q2s_pkg::*;

    localparam int DEPTH     = 16;
    localparam int N_RANDOM  = 400;
    localparam int CALM_TAIL = 60;
    localparam int PAD_W     = S_TDATA_W - VALUE_W - 2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } beat_t;

    typedef struct {
        logic [1:0]          op;
        logic [VALUE_W-1:0]  value;
        bit                  known;
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  res;
    } cmd_row_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [VALUE_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;

    // shadow of the queue ring and the stack
    logic [VALUE_W-1:0] q_mem [DEPTH];
    logic [VALUE_W-1:0] s_mem [DEPTH];
    int unsigned        q_head = 0;
    int unsigned        q_cnt  = 0;
    int unsigned        s_cnt  = 0;

    beat_t cmd_beats[$];
    beat_t pending_beats[$];
    int    errors = 0;
    bit    calm   = 1'b0;

    queue_to_stack_transfer #(.DEPTH(DEPTH)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5000000;
        $display("tb NOT OK");
        $finish;
    end

    // Work out the beats one command produces and advance the shadow state.
    function automatic void predict_command(input logic [1:0] op,
                                            input logic [VALUE_W-1:0] val);
        logic [VALUE_W-1:0] moved;
        int unsigned        idx;
        cmd_beats.delete();
        case (op)
            OP_ENQ:
            begin
                if (q_cnt >= DEPTH)
                begin
                    cmd_beats.push_back(beat_t'{STAT_QFULL, '0, 1'b1});
                end
                else
                begin
                    q_mem[(q_head + q_cnt) % DEPTH] = val;
                    q_cnt++;
                    cmd_beats.push_back(beat_t'{STAT_OK, val, 1'b1});
                end
            end
            OP_XFER:
            begin
                if (q_cnt == 0)
                begin
                    cmd_beats.push_back(beat_t'{STAT_QEMPTY, '0, 1'b1});
                end
                else
                begin
                    moved  = q_mem[q_head];
                    q_head = (q_head + 1) % DEPTH;
                    q_cnt--;
                    // head leaves the queue even when the stack cannot take it
                    if (s_cnt >= DEPTH)
                    begin
                        cmd_beats.push_back(beat_t'{STAT_SFULL, '0, 1'b1});
                    end
                    else
                    begin
                        s_mem[s_cnt] = moved;
                        s_cnt++;
                        cmd_beats.push_back(beat_t'{STAT_OK, moved, 1'b1});
                    end
                end
            end
            OP_LISTQ:
            begin
                if (q_cnt == 0)
                    cmd_beats.push_back(beat_t'{STAT_LEMPTY, '0, 1'b1});
                for (int unsigned i = 0; i < q_cnt; i++)
                    cmd_beats.push_back(beat_t'{STAT_ITEM, q_mem[(q_head + i) % DEPTH],
                                                i + 1 == q_cnt});
            end
            default:
            begin
                if (s_cnt == 0)
                    cmd_beats.push_back(beat_t'{STAT_LEMPTY, '0, 1'b1});
                for (int unsigned i = s_cnt; i > 0; i--)
                begin
                    idx = i - 1;
                    cmd_beats.push_back(beat_t'{STAT_ITEM, s_mem[idx], idx == 0});
                end
            end
        endcase
    endfunction

    task automatic send_cmd(input logic [1:0] op, input logic [VALUE_W-1:0] val,
                            input bit known, input logic [STATUS_W-1:0] st,
                            input logic [VALUE_W-1:0] res);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, val, op};
        do @(posedge clk); while (!s_tready);
        predict_command(op, val);
        if (known)
            pending_beats.push_back(beat_t'{st, res, 1'b1});
        else
            foreach (cmd_beats[i])
                pending_beats.push_back(cmd_beats[i]);
    endtask

    // Sink: stall in random bursts, hold ready high once the tail is reached.
    initial
    begin
        int n;
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                n = $urandom_range(1, 7);
            end
            else
            begin
                m_tready <= 1'b1;
                n = $urandom_range(1, 8);
            end
            repeat (n) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: status %0d value %h last %b",
                             m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (m_tuser !== want.status || m_tdata !== want.value || m_tlast !== want.last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp status %0d value %h last %b, got %0d %h %b",
                                 want.status, want.value, want.last, m_tuser, m_tdata, m_tlast);
                end
            end
        end
    end

    initial
    begin
        cmd_row_t   dir_rows [23];
        logic [1:0] sched_op [4];
        int         sched_len [4];
        logic [1:0] op;
        int         run;
        int         sent;
        int         k;

        dir_rows = '{
            '{OP_LISTQ, 32'h0000_0000, 1'b1, STAT_LEMPTY, 32'h0000_0000},
            '{OP_LISTS, 32'hFFFF_FFFF, 1'b1, STAT_LEMPTY, 32'h0000_0000},
            '{OP_XFER,  32'hDEAD_BEEF, 1'b1, STAT_QEMPTY, 32'h0000_0000},
            '{OP_ENQ,   32'h8000_0000, 1'b1, STAT_OK,     32'h8000_0000},
            '{OP_ENQ,   32'h7FFF_FFFF, 1'b1, STAT_OK,     32'h7FFF_FFFF},
            '{OP_ENQ,   32'h0000_0000, 1'b1, STAT_OK,     32'h0000_0000},
            '{OP_ENQ,   32'hFFFF_FFFF, 1'b1, STAT_OK,     32'hFFFF_FFFF},
            '{OP_ENQ,   32'h5555_5555, 1'b1, STAT_OK,     32'h5555_5555},
            '{OP_ENQ,   32'hAAAA_AAAA, 1'b1, STAT_OK,     32'hAAAA_AAAA},
            '{OP_LISTQ, 32'hFFFF_FFFF, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_XFER,  32'h0000_0000, 1'b1, STAT_OK,     32'h8000_0000},
            '{OP_XFER,  32'hFFFF_FFFF, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_LISTS, 32'h0000_0000, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_LISTQ, 32'h0000_0000, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_XFER,  32'h1234_5678, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_XFER,  32'h0000_0000, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_XFER,  32'h0000_0000, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_XFER,  32'h0000_0000, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_XFER,  32'h0000_0000, 1'b1, STAT_QEMPTY, 32'h0000_0000},
            '{OP_LISTQ, 32'h0000_0000, 1'b1, STAT_LEMPTY, 32'h0000_0000},
            '{OP_LISTS, 32'h0000_0000, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_ENQ,   32'h1234_5678, 1'b0, STAT_OK,     32'h0000_0000},
            '{OP_LISTQ, 32'h0000_0000, 1'b0, STAT_OK,     32'h0000_0000}
        };
        // overfill the queue, then drain it into the stack until both limits are hit
        sched_op  = '{OP_ENQ, OP_LISTQ, OP_XFER, OP_LISTS};
        sched_len = '{20, 1, 20, 1};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].op, dir_rows[i].value, dir_rows[i].known,
                     dir_rows[i].status, dir_rows[i].res);

        sent = 0;
        for (int e = 0; sent < N_RANDOM; e++)
        begin
            if (e < 4)
            begin
                op  = sched_op[e];
                run = sched_len[e];
            end
            else
            begin
                k = $urandom_range(0, 9);
                if (k < 4)
                begin
                    op  = OP_ENQ;
                    run = $urandom_range(1, 18);
                end
                else if (k < 7)
                begin
                    op  = OP_XFER;
                    run = $urandom_range(1, 18);
                end
                else
                begin
                    op  = (k < 9) ? OP_LISTQ : OP_LISTS;
                    run = 1;
                end
            end
            repeat (run)
            begin
                calm = (sent >= N_RANDOM - CALM_TAIL);
                send_cmd(op, $urandom(), 1'b0, STAT_OK, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (pending_beats.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/q2s_pkg.sv
rtl/queue_to_stack_transfer.sv
verif/tb.sv
